FILE: hdl/u8cjk_pkg.sv
package u8cjk_pkg;

    localparam int CP_W  = 21;
    localparam int LEN_W = 3;
    localparam int REM_W = 2;
    localparam int ST_W  = 2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_LEAD = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_CONT = 2'd2;
    localparam logic [ST_W-1:0] ST_TRUNC    = 2'd3;

    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

    localparam logic [REM_W-1:0] REM_IDLE = 2'd0;

    localparam logic [CP_W-1:0] CJK_MAIN_LO = 21'h04E00;
    localparam logic [CP_W-1:0] CJK_MAIN_HI = 21'h09FFF;
    localparam logic [CP_W-1:0] CJK_EXTA_LO = 21'h03400;
    localparam logic [CP_W-1:0] CJK_EXTA_HI = 21'h04DBF;
    localparam logic [CP_W-1:0] CJK_COMP_LO = 21'h0F900;
    localparam logic [CP_W-1:0] CJK_COMP_HI = 21'h0FAFF;
    localparam logic [CP_W-1:0] CJK_EXTB_LO = 21'h20000;
    localparam logic [CP_W-1:0] CJK_EXTB_HI = 21'h2A6DF;

    typedef struct packed {
        logic [REM_W-1:0] bytes_remaining;
        logic [CP_W-1:0]  code_accumulator;
        logic [LEN_W-1:0] sequence_length;
    } dec_state_t;

    typedef struct packed {
        logic [CP_W-1:0]  codepoint;
        logic [LEN_W-1:0] seq_length;
        logic             is_cjk;
        logic [ST_W-1:0]  status;
        logic             end_of_text;
    } result_t;

    function automatic logic in_cjk_range(input logic [CP_W-1:0] cp);
        in_cjk_range = (cp >= CJK_MAIN_LO && cp <= CJK_MAIN_HI) ||
                       (cp >= CJK_EXTA_LO && cp <= CJK_EXTA_HI) ||
                       (cp >= CJK_COMP_LO && cp <= CJK_COMP_HI) ||
                       (cp >= CJK_EXTB_LO && cp <= CJK_EXTB_HI);
    endfunction

endpackage

FILE: hdl/u8cjk_text_if.sv
interface u8cjk_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: hdl/u8cjk_symbol_if.sv
interface u8cjk_symbol_if;
    logic                         valid;
    logic                         ready;
    logic [u8cjk_pkg::CP_W-1:0]  codepoint;
    logic [u8cjk_pkg::LEN_W-1:0] seq_length;
    logic                         is_cjk;
    logic [u8cjk_pkg::ST_W-1:0]  status;
    logic                         end_of_text;

    modport source (output valid, output codepoint, output seq_length, output is_cjk,
                    output status, output end_of_text, input ready);
    modport sink (input valid, input codepoint, input seq_length, input is_cjk,
                  input status, input end_of_text, output ready);
endinterface

FILE: hdl/u8cjk_decode.sv
module u8cjk_decode
(
    input  u8cjk_pkg::dec_state_t state,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output u8cjk_pkg::dec_state_t state_next,
    output logic                  emit,
    output u8cjk_pkg::result_t    result
);

    localparam u8cjk_pkg::dec_state_t IDLE_STATE = '0;

    logic [u8cjk_pkg::CP_W-1:0]  acc_shift;
    logic [u8cjk_pkg::REM_W-1:0] rem_dec;
    logic [u8cjk_pkg::ST_W-1:0]  status;
    logic [u8cjk_pkg::CP_W-1:0]  cp;
    logic [u8cjk_pkg::LEN_W-1:0] len;

    assign acc_shift = {state.code_accumulator[u8cjk_pkg::CP_W-7:0], data_byte[5:0]};
    assign rem_dec   = state.bytes_remaining - 2'd1;

    always_comb
    begin
        state_next = IDLE_STATE;
        emit       = 1'b1;
        status     = u8cjk_pkg::ST_OK;
        cp         = '0;
        len        = u8cjk_pkg::LEN_NONE;
        if (state.bytes_remaining == u8cjk_pkg::REM_IDLE)
        begin
            priority if (data_byte[7] == 1'b0)
            begin
                cp  = {13'd0, data_byte};
                len = u8cjk_pkg::LEN_ONE;
            end
            else if (data_byte[7:5] == 3'b110 || data_byte[7:4] == 4'b1110 ||
                     data_byte[7:3] == 5'b11110)
            begin
                if (last_byte)
                begin
                    status = u8cjk_pkg::ST_TRUNC;
                end
                else
                begin
                    emit = 1'b0;
                    priority if (data_byte[7:5] == 3'b110)
                    begin
                        state_next.code_accumulator = {16'd0, data_byte[4:0]};
                        state_next.sequence_length  = u8cjk_pkg::LEN_TWO;
                        state_next.bytes_remaining  = 2'd1;
                    end
                    else if (data_byte[7:4] == 4'b1110)
                    begin
                        state_next.code_accumulator = {17'd0, data_byte[3:0]};
                        state_next.sequence_length  = u8cjk_pkg::LEN_THREE;
                        state_next.bytes_remaining  = 2'd2;
                    end
                    else
                    begin
                        state_next.code_accumulator = {18'd0, data_byte[2:0]};
                        state_next.sequence_length  = u8cjk_pkg::LEN_FOUR;
                        state_next.bytes_remaining  = 2'd3;
                    end
                end
            end
            else
            begin
                status = u8cjk_pkg::ST_BAD_LEAD;
            end
        end
        else
        begin
            priority if (data_byte[7:6] != 2'b10)
            begin
                status = u8cjk_pkg::ST_BAD_CONT;
            end
            else if (rem_dec == u8cjk_pkg::REM_IDLE)
            begin
                cp  = acc_shift;
                len = state.sequence_length;
            end
            else if (last_byte)
            begin
                status = u8cjk_pkg::ST_TRUNC;
            end
            else
            begin
                emit                        = 1'b0;
                state_next.code_accumulator = acc_shift;
                state_next.sequence_length  = state.sequence_length;
                state_next.bytes_remaining  = rem_dec;
            end
        end
    end

    always_comb
    begin
        result.codepoint   = cp;
        result.seq_length  = len;
        result.status      = status;
        result.is_cjk      = (status == u8cjk_pkg::ST_OK) && u8cjk_pkg::in_cjk_range(cp);
        result.end_of_text = last_byte;
    end

endmodule

FILE: hdl/utf8_decoder_cjk_classify_core.sv
// channel  role    payload                                          transfer
// text     sink    data_byte[8], last_byte[1]                       valid & ready
// symbol   source  codepoint[21], seq_length[3], is_cjk[1],         valid & ready
//                  status[2], end_of_text[1]
//
// one byte per cycle unstalled: input register, one decode step, result register
// a byte's result leaves via the input and result registers, or none mid-sequence
// reset clears the pending sequence and both valid flags
// a stalled result holds the decode stage; text keeps flowing while bytes emit nothing
module utf8_decoder_cjk_classify_core
(
    input logic                  clk,
    input logic                  rst_n,
    u8cjk_text_if.sink           text,
    u8cjk_symbol_if.source       symbol
);

    logic                  s0_valid_reg;
    logic [7:0]            s0_byte_reg;
    logic                  s0_last_reg;
    u8cjk_pkg::dec_state_t state_reg;
    u8cjk_pkg::dec_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    u8cjk_pkg::result_t    out_data_reg;
    u8cjk_pkg::result_t    dec_result;
    logic                  dec_emit;
    logic                  s0_go;
    logic                  text_xfer;

    u8cjk_decode u_decode
    (
        .state      (state_reg),
        .data_byte  (s0_byte_reg),
        .last_byte  (s0_last_reg),
        .state_next (state_next),
        .emit       (dec_emit),
        .result     (dec_result)
    );

    assign s0_go      = s0_valid_reg && (!dec_emit || !out_valid_reg || symbol.ready);
    assign text.ready = !s0_valid_reg || s0_go;
    assign text_xfer  = text.valid && text.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s0_go && dec_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (symbol.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (text.ready)
            begin
                s0_valid_reg <= text.valid;
            end
            if (s0_go)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_xfer)
        begin
            s0_byte_reg <= text.data_byte;
            s0_last_reg <= text.last_byte;
        end
        if (s0_go && dec_emit)
        begin
            out_data_reg <= dec_result;
        end
    end

    assign symbol.valid       = out_valid_reg;
    assign symbol.codepoint   = out_data_reg.codepoint;
    assign symbol.seq_length  = out_data_reg.seq_length;
    assign symbol.is_cjk      = out_data_reg.is_cjk;
    assign symbol.status      = out_data_reg.status;
    assign symbol.end_of_text = out_data_reg.end_of_text;

endmodule
